>>> src/dss_pkg.sv
// shared constants, codes and types for the two-stacks-in-one-store block
// no dependencies
package dss_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = 5;

    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_POP  = 2'd1;
    localparam logic [1:0] CMD_PEEK = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic SIDE_LEFT = 1'b0;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic             valid;
        logic             use_rd;
        logic [1:0]       status;
        logic [CNT_W-1:0] left;
        logic [CNT_W-1:0] right;
    } t_pend;

endpackage

>>> src/dss_ram.sv
// single-port-write, single-port-read synchronous store, registered read data
// no dependencies
module dss_ram #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

>>> src/dss_ctrl.sv
// stack pointers, capacity register and request decode
// depends on dss_pkg
module dss_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [dss_pkg::CNT_W-1:0]        i_cfg_data,
    input  logic                             i_acc,
    input  logic [1:0]                       i_cmd,
    input  logic                             i_side,
    input  logic signed [dss_pkg::DATA_W-1:0] i_push_value,
    output dss_pkg::t_mem_req                o_mem,
    output dss_pkg::t_pend                   o_pend
);
    import dss_pkg::*;

    logic [CNT_W-1:0] r_cap;
    logic [CNT_W-1:0] r_left;
    logic [CNT_W-1:0] r_right;
    logic [CNT_W-1:0] n_left;
    logic [CNT_W-1:0] n_right;
    logic [CNT_W-1:0] cap_eff;
    logic [CNT_W:0]   used;
    logic [CNT_W-1:0] idx;
    t_pend            r_pend;
    t_pend            n_pend;

    assign cap_eff = (r_cap == '0) ? CNT_W'(1) :
                     (r_cap > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : r_cap;
    assign used    = {1'b0, r_left} + {1'b0, r_right};

    always_comb begin
        n_left        = r_left;
        n_right       = r_right;
        idx           = '0;
        o_mem         = '0;
        o_mem.wdata   = i_push_value;
        n_pend.valid  = i_acc;
        n_pend.use_rd = 1'b0;
        n_pend.status = ST_OK;
        case (i_cmd) inside
            CMD_PUSH: begin
                if (used >= {1'b0, cap_eff}) begin
                    n_pend.status = ST_FULL;
                end else if (i_side == SIDE_LEFT) begin
                    idx      = r_left;
                    o_mem.we = i_acc;
                    n_left   = r_left + CNT_W'(1);
                end else begin
                    idx      = cap_eff - CNT_W'(1) - r_right;
                    o_mem.we = i_acc;
                    n_right  = r_right + CNT_W'(1);
                end
            end
            CMD_POP, CMD_PEEK: begin
                if ((i_side == SIDE_LEFT ? r_left : r_right) == '0) begin
                    n_pend.status = ST_EMPTY;
                end else begin
                    n_pend.use_rd = 1'b1;
                    o_mem.re      = i_acc;
                    if (i_side == SIDE_LEFT) begin
                        idx = r_left - CNT_W'(1);
                        if (i_cmd == CMD_POP) begin
                            n_left = r_left - CNT_W'(1);
                        end
                    end else begin
                        idx = cap_eff - r_right;
                        if (i_cmd == CMD_POP) begin
                            n_right = r_right - CNT_W'(1);
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        o_mem.waddr  = idx[ADDR_W-1:0];
        o_mem.raddr  = idx[ADDR_W-1:0];
        n_pend.left  = n_left;
        n_pend.right = n_right;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap        <= CNT_W'(DEPTH);
            r_left       <= '0;
            r_right      <= '0;
            r_pend.valid <= 1'b0;
        end else begin
            r_pend <= n_pend;
            if (i_cfg_valid) begin
                r_cap   <= i_cfg_data;
                r_left  <= '0;
                r_right <= '0;
            end else if (i_acc) begin
                r_left  <= n_left;
                r_right <= n_right;
            end
        end
    end

    assign o_pend = r_pend;

endmodule

>>> src/dual_stack_shared_array.sv
// top level: two stacks sharing one store, request and result channels
// depends on dss_pkg, dss_ctrl, dss_ram
//
//  channel  | direction | handshake              | payload
//  request  | in        | i_in_valid / o_in_stall | i_cmd, i_side, i_push_value
//  result   | out       | o_out_valid / i_out_stall | o_top_value, o_status,
//           |           |                        | o_left_count, o_right_count
//  config   | in        | i_cfg_valid / o_cfg_ready | i_cfg_data (capacity)
//
// an accepted request registers its store read and pending entry, then the
// result register loads; no request is taken while one is pending
// reset clears both stack depths and sets capacity to 16; store contents are
// not cleared, so no sweep follows reset
// the result register holds while i_out_stall is high; requests stall meanwhile
module dual_stack_shared_array (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_cmd,
    input  logic                              i_side,
    input  logic signed [dss_pkg::DATA_W-1:0] i_push_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [dss_pkg::DATA_W-1:0] o_top_value,
    output logic [1:0]                        o_status,
    output logic [dss_pkg::CNT_W-1:0]         o_left_count,
    output logic [dss_pkg::CNT_W-1:0]         o_right_count,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [dss_pkg::CNT_W-1:0]         i_cfg_data
);
    import dss_pkg::*;

    t_mem_req          mem_req;
    t_pend             pend;
    logic [DATA_W-1:0] rd_data;
    logic              in_acc;
    logic              out_acc;
    logic              r_out_valid;

    assign o_in_stall  = pend.valid | (r_out_valid & i_out_stall);
    assign in_acc      = i_in_valid & ~o_in_stall;
    assign out_acc     = r_out_valid & ~i_out_stall;
    assign o_cfg_ready = 1'b1;

    dss_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_acc        (in_acc),
        .i_cmd        (i_cmd),
        .i_side       (i_side),
        .i_push_value (i_push_value),
        .o_mem        (mem_req),
        .o_pend       (pend)
    );

    dss_ram #(
        .DEPTH  (DEPTH),
        .DATA_W (DATA_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_re    (mem_req.re),
        .i_raddr (mem_req.raddr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pend.valid) begin
            r_out_valid   <= 1'b1;
            o_top_value   <= pend.use_rd ? rd_data : '0;
            o_status      <= pend.status;
            o_left_count  <= pend.left;
            o_right_count <= pend.right;
        end else if (out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    a_acc_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> pend.valid)
        else $error("accepted transaction not pending");

    a_pend_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pend.valid |=> r_out_valid)
        else $error("pending transaction did not reach result register");

    a_pend_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pend.valid |-> o_in_stall)
        else $error("request taken while read in flight");

    a_count_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ({1'b0, o_left_count} + {1'b0, o_right_count}
                         <= (CNT_W+1)'(DEPTH)))
        else $error("stack depths exceed store");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench for dual_stack_shared_array: directed and random push/pop/peek traffic
// depends on dss_pkg and the dual_stack_shared_array rtl
module tb_top;
    import dss_pkg::*;

    localparam logic [1:0] CMD_NOP     = 2'd3;
    localparam logic       SIDE_RIGHT  = 1'b1;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         SEG_ITEMS   = 140;

    typedef struct {
        logic [1:0]               cmd;
        logic                     side;
        logic signed [DATA_W-1:0] value;
    } t_stack_req;

    typedef struct {
        logic signed [DATA_W-1:0] top;
        logic [1:0]               status;
        logic [CNT_W-1:0]         lcount;
        logic [CNT_W-1:0]         rcount;
    } t_stack_rsp;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [1:0]               i_cmd = CMD_NOP;
    logic                     i_side = 1'b0;
    logic signed [DATA_W-1:0] i_push_value = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic signed [DATA_W-1:0] o_top_value;
    logic [1:0]               o_status;
    logic [CNT_W-1:0]         o_left_count;
    logic [CNT_W-1:0]         o_right_count;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CNT_W-1:0]         i_cfg_data = '0;

    t_stack_req pending_requests[$];
    t_stack_rsp expected_results[$];

    // shadow copy of the block state
    logic [DATA_W-1:0] stack_mem [DEPTH];
    logic [CNT_W-1:0]  cap_setting = 5'd16;
    int                lhs_depth = 0;
    int                rhs_depth = 0;

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  hold_len = 0;
    int  hold_asks = 0;
    int  hold_seen = 0;
    int  hold_left = 0;
    int  mismatches = 0;
    int  cycle_count = 0;
    bit  req_taken = 1'b0;

    dual_stack_shared_array dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_side        (i_side),
        .i_push_value  (i_push_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_top_value   (o_top_value),
        .o_status      (o_status),
        .o_left_count  (o_left_count),
        .o_right_count (o_right_count),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_stack_rsp predict_stack_op(input t_stack_req r);
        t_stack_rsp rsp;
        int eff;
        int d;
        int idx;
        eff = cap_setting;
        if (eff < 1) eff = 1;
        if (eff > DEPTH) eff = DEPTH;
        rsp.top = '0;
        rsp.status = ST_OK;
        case (r.cmd) inside
            CMD_PUSH: begin
                if (lhs_depth + rhs_depth >= eff) begin
                    rsp.status = ST_FULL;
                end else if (r.side == SIDE_LEFT) begin
                    stack_mem[ADDR_W'(lhs_depth)] = r.value;
                    lhs_depth++;
                end else begin
                    stack_mem[ADDR_W'(eff - 1 - rhs_depth)] = r.value;
                    rhs_depth++;
                end
            end
            CMD_POP, CMD_PEEK: begin
                d = (r.side == SIDE_RIGHT) ? rhs_depth : lhs_depth;
                if (d == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    idx = (r.side == SIDE_RIGHT) ? eff - rhs_depth : lhs_depth - 1;
                    rsp.top = stack_mem[ADDR_W'(idx)];
                    if (r.cmd == CMD_POP) begin
                        if (r.side == SIDE_RIGHT) rhs_depth--;
                        else lhs_depth--;
                    end
                end
            end
            default: ;
        endcase
        rsp.lcount = CNT_W'(lhs_depth);
        rsp.rcount = CNT_W'(rhs_depth);
        return rsp;
    endfunction

    task automatic check_field(input string fname, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %0h, got %0h", fname, want, got);
        end
    endtask

    // monitor: model update on each transaction, result compare
    always @(posedge i_clk) begin
        t_stack_rsp want;
        t_stack_req seen;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end else begin
            req_taken = i_rst_n && i_in_valid && !o_in_stall;
            if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
                cap_setting = i_cfg_data;
                lhs_depth = 0;
                rhs_depth = 0;
            end
            if (req_taken) begin
                seen.cmd = i_cmd;
                seen.side = i_side;
                seen.value = i_push_value;
                expected_results.push_back(predict_stack_op(seen));
            end
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result with no request outstanding: top %0h status %0d",
                                 o_top_value, o_status);
                end else begin
                    want = expected_results.pop_front();
                    check_field("top_value", want.top, o_top_value);
                    check_field("status", DATA_W'(want.status), DATA_W'(o_status));
                    check_field("left_count", DATA_W'(want.lcount), DATA_W'(o_left_count));
                    check_field("right_count", DATA_W'(want.rcount),
                                DATA_W'(o_right_count));
                end
            end
        end
    end

    // request driver
    always @(negedge i_clk) begin
        t_stack_req nxt;
        if (!i_in_valid || req_taken) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = pending_requests.pop_front();
                i_in_valid <= 1'b1;
                i_cmd <= nxt.cmd;
                i_side <= nxt.side;
                i_push_value <= nxt.value;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result stall driver, with long hold-offs on request
    always @(negedge i_clk) begin
        if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = hold_len;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    function automatic t_stack_req req(input logic [1:0] cmd, input logic side,
                                       input logic [DATA_W-1:0] value);
        t_stack_req r;
        r.cmd = cmd;
        r.side = side;
        r.value = value;
        return r;
    endfunction

    function automatic t_stack_req random_request(input int push_pct);
        t_stack_req r;
        int roll;
        roll = $urandom_range(99);
        if (roll < 4) r.cmd = CMD_NOP;
        else if (roll < 4 + push_pct * 96 / 100) r.cmd = CMD_PUSH;
        else if ($urandom_range(2) == 0) r.cmd = CMD_PEEK;
        else r.cmd = CMD_POP;
        r.side = 1'($urandom_range(1));
        case ($urandom_range(11))
            0: r.value = 32'h7fff_ffff;
            1: r.value = 32'h8000_0000;
            2: r.value = '0;
            3: r.value = '1;
            default: r.value = $urandom;
        endcase
        return r;
    endfunction

    task automatic step();
        @(posedge i_clk);
        #1;
    endtask

    task automatic wait_drained();
        while ((i_in_valid && !req_taken) || pending_requests.size() != 0 ||
               expected_results.size() != 0)
            step();
        repeat (4) step();
    endtask

    task automatic write_capacity(input logic [CNT_W-1:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic queue_random(input int count);
        int bias;
        bias = 50;
        for (int k = 0; k < count; k++) begin
            if (k % 20 == 0) begin
                case ($urandom_range(2))
                    0: bias = 75;
                    1: bias = 25;
                    default: bias = 50;
                endcase
            end
            pending_requests.push_back(random_request(bias));
        end
    endtask

    initial begin
        logic [CNT_W-1:0] seg_cap;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        step();

        send_idle_pct = 30;
        recv_idle_pct = 68;

        // reset capacity: empty errors, extremes, unused command
        pending_requests.push_back(req(CMD_POP, SIDE_LEFT, 32'h1234_5678));
        pending_requests.push_back(req(CMD_PEEK, SIDE_RIGHT, '0));
        pending_requests.push_back(req(CMD_PUSH, SIDE_LEFT, 32'h7fff_ffff));
        pending_requests.push_back(req(CMD_PUSH, SIDE_RIGHT, 32'h8000_0000));
        pending_requests.push_back(req(CMD_PEEK, SIDE_LEFT, '1));
        pending_requests.push_back(req(CMD_PEEK, SIDE_RIGHT, '0));
        pending_requests.push_back(req(CMD_NOP, SIDE_RIGHT, '1));
        pending_requests.push_back(req(CMD_PUSH, SIDE_LEFT, '0));
        pending_requests.push_back(req(CMD_PUSH, SIDE_RIGHT, '1));
        pending_requests.push_back(req(CMD_POP, SIDE_RIGHT, '0));
        pending_requests.push_back(req(CMD_POP, SIDE_LEFT, '0));
        pending_requests.push_back(req(CMD_POP, SIDE_LEFT, '0));
        pending_requests.push_back(req(CMD_POP, SIDE_RIGHT, '0));
        pending_requests.push_back(req(CMD_POP, SIDE_RIGHT, '0));
        wait_drained();

        // small store: stacks meet, full and empty on both sides
        write_capacity(5'd3);
        pending_requests.push_back(req(CMD_PUSH, SIDE_LEFT, 32'h0000_00a1));
        pending_requests.push_back(req(CMD_PUSH, SIDE_RIGHT, 32'hdead_beef));
        pending_requests.push_back(req(CMD_PUSH, SIDE_LEFT, 32'h5555_aaaa));
        pending_requests.push_back(req(CMD_PUSH, SIDE_RIGHT, 32'h0000_0001));
        pending_requests.push_back(req(CMD_PUSH, SIDE_LEFT, 32'h0000_0002));
        pending_requests.push_back(req(CMD_PEEK, SIDE_LEFT, '0));
        pending_requests.push_back(req(CMD_POP, SIDE_RIGHT, '0));
        pending_requests.push_back(req(CMD_POP, SIDE_RIGHT, '0));
        pending_requests.push_back(req(CMD_POP, SIDE_LEFT, '0));
        pending_requests.push_back(req(CMD_POP, SIDE_LEFT, '0));
        pending_requests.push_back(req(CMD_POP, SIDE_LEFT, '0));
        wait_drained();

        for (int seg = 0; seg < 9; seg++) begin
            case (seg / 3)
                0: begin
                    send_idle_pct = 30;
                    recv_idle_pct = 68;
                end
                1: begin
                    send_idle_pct = 68;
                    recv_idle_pct = 30;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (seg)
                0: seg_cap = 5'd0;
                1: seg_cap = 5'd31;
                2: seg_cap = 5'd1;
                3: seg_cap = 5'd2;
                4: seg_cap = 5'd17;
                5: seg_cap = 5'd5;
                6: seg_cap = 5'd16;
                7: seg_cap = CNT_W'($urandom_range(16, 1));
                default: seg_cap = 5'd8;
            endcase
            write_capacity(seg_cap);
            if (seg == 6) begin
                // long result hold-off so the block backs up and stalls requests
                hold_len = 80;
                hold_asks++;
            end
            if (seg == 4) begin
                queue_random(SEG_ITEMS / 2);
                wait_drained();
                queue_random(SEG_ITEMS / 2);
            end else begin
                queue_random(SEG_ITEMS);
            end
            wait_drained();
        end

        repeat (12) step();
        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

>>> files.f
src/dss_pkg.sv
src/dss_ram.sv
src/dss_ctrl.sv
src/dual_stack_shared_array.sv
tb/tb_top.sv
